>>> rtl/tic_pkg.sv
// Package for the Thumb instruction classifier: class codes, prefix event
// codes and the opcode patterns of the BL/BLX prefix and suffix halfwords.
// No dependencies.
package tic_pkg;

  typedef logic [5:0] cls_t;
  typedef logic [2:0] pfx_ev_t;

  localparam cls_t CLS_SHIFT_IMM    = 6'd0;
  localparam cls_t CLS_ASR_IMM      = 6'd1;
  localparam cls_t CLS_ADDSUB_REG   = 6'd2;
  localparam cls_t CLS_ADDSUB_IMM3  = 6'd3;
  localparam cls_t CLS_MOVCMP_IMM8  = 6'd4;
  localparam cls_t CLS_ADDSUB_IMM8  = 6'd5;
  localparam cls_t CLS_LDR_PC       = 6'd6;
  localparam cls_t CLS_ALU_AND      = 6'd7;
  localparam cls_t CLS_ALU_ASR      = 6'd8;
  localparam cls_t CLS_ALU_TST      = 6'd9;
  localparam cls_t CLS_ALU_ORR      = 6'd10;
  localparam cls_t CLS_CPY          = 6'd11;
  localparam cls_t CLS_HI_LH        = 6'd12;
  localparam cls_t CLS_HI_HL        = 6'd13;
  localparam cls_t CLS_HI_HH        = 6'd14;
  localparam cls_t CLS_CMP_LH       = 6'd15;
  localparam cls_t CLS_CMP_HL       = 6'd16;
  localparam cls_t CLS_CMP_HH       = 6'd17;
  localparam cls_t CLS_BX_REG       = 6'd18;
  localparam cls_t CLS_STR_REG      = 6'd19;
  localparam cls_t CLS_LDR_REG      = 6'd20;
  localparam cls_t CLS_LDST_IMM5    = 6'd21;
  localparam cls_t CLS_LDSTB_IMM5   = 6'd22;
  localparam cls_t CLS_LDSTH_IMM5   = 6'd23;
  localparam cls_t CLS_LDST_SP      = 6'd24;
  localparam cls_t CLS_ADD_PCSP     = 6'd25;
  localparam cls_t CLS_ADJ_SP       = 6'd26;
  localparam cls_t CLS_EXTEND       = 6'd27;
  localparam cls_t CLS_PUSH_POP     = 6'd28;
  localparam cls_t CLS_SETEND       = 6'd29;
  localparam cls_t CLS_CPS          = 6'd30;
  localparam cls_t CLS_REV          = 6'd31;
  localparam cls_t CLS_BKPT         = 6'd32;
  localparam cls_t CLS_LDM_STM      = 6'd33;
  localparam cls_t CLS_BCOND        = 6'd34;
  localparam cls_t CLS_UDF          = 6'd35;
  localparam cls_t CLS_SWI          = 6'd36;
  localparam cls_t CLS_B            = 6'd37;
  localparam cls_t CLS_BLX_SUFFIX   = 6'd38;
  localparam cls_t CLS_BL_SUFFIX    = 6'd39;
  localparam cls_t CLS_UNDEF        = 6'd40;
  localparam cls_t CLS_PREFIX       = 6'd41;

  localparam pfx_ev_t EV_NONE       = 3'd0;
  localparam pfx_ev_t EV_HELD       = 3'd1;
  localparam pfx_ev_t EV_ORPHAN_NEW = 3'd2;
  localparam pfx_ev_t EV_ORPHAN     = 3'd3;
  localparam pfx_ev_t EV_PAIRED     = 3'd4;

  localparam logic [4:0] OP5_PREFIX     = 5'h1E;
  localparam logic [4:0] OP5_BLX_SUFFIX = 5'h1D;
  localparam logic [4:0] OP5_BL_SUFFIX  = 5'h1F;

endpackage

>>> rtl/tic_decode.sv
// Combinational decode tree that maps one Thumb halfword to its class code.
// Depends on tic_pkg for the class codes.
module tic_decode (
  input  logic [15:0]       instr,
  output tic_pkg::cls_t     instr_class
);

  logic [3:0] hi_op;
  logic [3:0] sub_op;

  assign hi_op  = instr[9:6];
  assign sub_op = instr[11:8];

  always_comb begin
    instr_class = tic_pkg::CLS_UNDEF;
    case (instr[15:12])
      4'h0: instr_class = tic_pkg::CLS_SHIFT_IMM;
      4'h1: begin
        case (instr[11:10])
          2'd2:    instr_class = tic_pkg::CLS_ADDSUB_REG;
          2'd3:    instr_class = tic_pkg::CLS_ADDSUB_IMM3;
          default: instr_class = tic_pkg::CLS_ASR_IMM;
        endcase
      end
      4'h2: instr_class = tic_pkg::CLS_MOVCMP_IMM8;
      4'h3: instr_class = tic_pkg::CLS_ADDSUB_IMM8;
      4'h4: begin
        if (instr[11]) begin
          instr_class = tic_pkg::CLS_LDR_PC;
        end else if (!instr[10]) begin
          case (instr[9:8])
            2'd0:    instr_class = tic_pkg::CLS_ALU_AND;
            2'd1:    instr_class = tic_pkg::CLS_ALU_ASR;
            2'd2:    instr_class = tic_pkg::CLS_ALU_TST;
            default: instr_class = tic_pkg::CLS_ALU_ORR;
          endcase
        end else if (hi_op inside {4'd0, 4'd4}) begin
          instr_class = tic_pkg::CLS_UNDEF;
        end else if (hi_op inside {[4'd12:4'd15]}) begin
          instr_class = tic_pkg::CLS_BX_REG;
        end else begin
          // Codes 8 to 11 decode by their low three bits, so 8 becomes CPY.
          case (hi_op[2:0])
            3'd0:    instr_class = tic_pkg::CLS_CPY;
            3'd1:    instr_class = tic_pkg::CLS_HI_LH;
            3'd2:    instr_class = tic_pkg::CLS_HI_HL;
            3'd3:    instr_class = tic_pkg::CLS_HI_HH;
            3'd5:    instr_class = tic_pkg::CLS_CMP_LH;
            3'd6:    instr_class = tic_pkg::CLS_CMP_HL;
            3'd7:    instr_class = tic_pkg::CLS_CMP_HH;
            default: instr_class = tic_pkg::CLS_UNDEF;
          endcase
        end
      end
      4'h5: instr_class = instr[11] ? tic_pkg::CLS_LDR_REG : tic_pkg::CLS_STR_REG;
      4'h6: instr_class = tic_pkg::CLS_LDST_IMM5;
      4'h7: instr_class = tic_pkg::CLS_LDSTB_IMM5;
      4'h8: instr_class = tic_pkg::CLS_LDSTH_IMM5;
      4'h9: instr_class = tic_pkg::CLS_LDST_SP;
      4'hA: instr_class = tic_pkg::CLS_ADD_PCSP;
      4'hB: begin
        case (sub_op)
          4'h0: instr_class = tic_pkg::CLS_ADJ_SP;
          4'h2: instr_class = tic_pkg::CLS_EXTEND;
          4'h4, 4'h5, 4'hC, 4'hD: instr_class = tic_pkg::CLS_PUSH_POP;
          4'h6: begin
            if (instr[7:4] == 4'h5 && instr[2:0] == 3'd0) begin
              instr_class = tic_pkg::CLS_SETEND;
            end else if (instr[7:5] == 3'd3 && !instr[3]) begin
              instr_class = tic_pkg::CLS_CPS;
            end else begin
              instr_class = tic_pkg::CLS_UNDEF;
            end
          end
          4'hA: instr_class = tic_pkg::CLS_REV;
          4'hE: instr_class = tic_pkg::CLS_BKPT;
          default: instr_class = tic_pkg::CLS_UNDEF;
        endcase
      end
      4'hC: instr_class = tic_pkg::CLS_LDM_STM;
      4'hD: begin
        if (sub_op inside {[4'h0:4'hD]}) begin
          instr_class = tic_pkg::CLS_BCOND;
        end else begin
          instr_class = sub_op[0] ? tic_pkg::CLS_SWI : tic_pkg::CLS_UDF;
        end
      end
      4'hE: begin
        if (instr[11]) begin
          // A BLX suffix must have bit 0 clear.
          instr_class = instr[0] ? tic_pkg::CLS_UNDEF : tic_pkg::CLS_BLX_SUFFIX;
        end else begin
          instr_class = tic_pkg::CLS_B;
        end
      end
      default: instr_class = tic_pkg::CLS_BL_SUFFIX;
    endcase
  end

endmodule

>>> rtl/thumb_instruction_classifier.sv
// Top level of the Thumb instruction classifier: input register, prefix
// tracking and result register. Depends on tic_pkg and tic_decode.
//
// Classifies one 16-bit Thumb halfword per clock cycle while out_stall allows it
// and gives one result per halfword, held first in the input register and then
// in the result register. The input register also serves as a skid stage: it
// takes one new request while a finished result waits, then stalls the input.
// The only loop is the one-bit pending-prefix flag with its 11-bit offset,
// updated as a halfword moves into the result register. A BL/BLX prefix is
// held and reported as paired by the next BL or BLX suffix, or as orphaned
// by any other halfword, a second prefix included.
module thumb_instruction_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_instr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_instr_class,
  output logic [2:0]  out_prefix_event,
  output logic [10:0] out_prefix_offset,
  output logic        out_prefix_pending
);

  logic                s1_valid_r;
  logic [15:0]         s1_instr_r;
  logic                out_valid_r;
  tic_pkg::cls_t       cls_r;
  tic_pkg::pfx_ev_t    ev_r;
  logic [10:0]         off_r;
  logic                pending_r;
  logic                held_r;
  logic [10:0]         held_off_r;

  tic_pkg::cls_t       dec_cls;
  tic_pkg::cls_t       cls_nxt;
  tic_pkg::pfx_ev_t    ev_nxt;
  logic [10:0]         off_nxt;
  logic                held_nxt;
  logic [10:0]         held_off_nxt;
  logic [4:0]          op5;
  logic                advance;
  logic                in_take;

  tic_decode u_decode (
    .instr       (s1_instr_r),
    .instr_class (dec_cls)
  );

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign op5      = s1_instr_r[15:11];

  always_comb begin
    cls_nxt      = dec_cls;
    ev_nxt       = tic_pkg::EV_NONE;
    off_nxt      = '0;
    held_nxt     = held_r;
    held_off_nxt = held_off_r;
    if (op5 == tic_pkg::OP5_PREFIX) begin
      cls_nxt      = tic_pkg::CLS_PREFIX;
      ev_nxt       = held_r ? tic_pkg::EV_ORPHAN_NEW : tic_pkg::EV_HELD;
      off_nxt      = held_r ? held_off_r : 11'd0;
      held_nxt     = 1'b1;
      held_off_nxt = s1_instr_r[10:0];
    end else if (held_r) begin
      ev_nxt       = (op5 == tic_pkg::OP5_BLX_SUFFIX || op5 == tic_pkg::OP5_BL_SUFFIX)
                     ? tic_pkg::EV_PAIRED : tic_pkg::EV_ORPHAN;
      off_nxt      = held_off_r;
      held_nxt     = 1'b0;
      held_off_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= 1'b0;
      held_off_r  <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        held_r      <= held_nxt;
        held_off_r  <= held_off_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_instr_r <= in_instr;
    end
    if (advance) begin
      cls_r     <= cls_nxt;
      ev_r      <= ev_nxt;
      off_r     <= off_nxt;
      pending_r <= held_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_instr_class    = cls_r;
  assign out_prefix_event   = ev_r;
  assign out_prefix_offset  = off_r;
  assign out_prefix_pending = pending_r;

  // A prefix is pending after a result exactly when that result captured one.
  a_pending_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pending_r == (ev_r == tic_pkg::EV_HELD ||
                                   ev_r == tic_pkg::EV_ORPHAN_NEW)))
    else $error("pending flag disagrees with prefix event");

  // The prefix class and the capturing events always come together.
  a_prefix_class_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((cls_r == tic_pkg::CLS_PREFIX) == (ev_r == tic_pkg::EV_HELD ||
                                                        ev_r == tic_pkg::EV_ORPHAN_NEW)))
    else $error("prefix class without capture event");

  // No earlier prefix means no offset is reported.
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ev_r == tic_pkg::EV_NONE || ev_r == tic_pkg::EV_HELD))
      |-> (off_r == 11'd0))
    else $error("offset reported without an earlier prefix");

  // The held offset is cleared whenever no prefix is held.
  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (held_off_r == 11'd0))
    else $error("stale held offset");

  // The flag leaving the result register tracks the live prefix state.
  a_pending_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (pending_r == held_r))
    else $error("pending output out of step with prefix state");

endmodule

>>> bench/thumb_instruction_classifier_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for thumb_instruction_classifier: random and directed
// halfwords, BL/BLX prefix pairing tracked by a local predictor. Uses tic_pkg.
module thumb_instruction_classifier_tb;

  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_FROM    = 300;
  localparam int CALM_TO      = 700;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [15:0]      instr;
    tic_pkg::cls_t    instr_class;
    tic_pkg::pfx_ev_t prefix_event;
    logic [10:0]      prefix_offset;
    logic             prefix_pending;
  } decode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_instr = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_instr_class;
  logic [2:0]  out_prefix_event;
  logic [10:0] out_prefix_offset;
  logic        out_prefix_pending;

  logic [15:0] halfword_q[$];
  decode_t     predicted_decodes[$];
  logic        bl_prefix_held = 1'b0;
  logic [10:0] bl_prefix_offset = 11'd0;
  int          cycle_count = 0;
  int          total_items = 0;
  int          accepted_items = 0;
  int          error_count = 0;

  thumb_instruction_classifier dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_instr           (in_instr),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_instr_class    (out_instr_class),
    .out_prefix_event   (out_prefix_event),
    .out_prefix_offset  (out_prefix_offset),
    .out_prefix_pending (out_prefix_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle at random, except inside a window of cycles where both sides run flat out.
  function automatic bit take_break();
    return (cycle_count < CALM_FROM || cycle_count >= CALM_TO) &&
           ($urandom_range(99) < 30);
  endfunction

  function automatic tic_pkg::cls_t classify_halfword(logic [15:0] w);
    logic [3:0] t;
    t = w[9:6];
    case (w[15:12])
      4'h0: return tic_pkg::CLS_SHIFT_IMM;
      4'h1: begin
        if (!w[11]) return tic_pkg::CLS_ASR_IMM;
        return w[10] ? tic_pkg::CLS_ADDSUB_IMM3 : tic_pkg::CLS_ADDSUB_REG;
      end
      4'h2: return tic_pkg::CLS_MOVCMP_IMM8;
      4'h3: return tic_pkg::CLS_ADDSUB_IMM8;
      4'h4: begin
        if (w[11]) return tic_pkg::CLS_LDR_PC;
        if (!w[10]) return tic_pkg::cls_t'(tic_pkg::CLS_ALU_AND + tic_pkg::cls_t'(w[9:8]));
        if (t == 4'd0 || t == 4'd4) return tic_pkg::CLS_UNDEF;
        if (t >= 4'd12) return tic_pkg::CLS_BX_REG;
        // Hi-register forms 8..11 fold onto 0..7 by the low three bits.
        case (t[2:0])
          3'd0: return tic_pkg::CLS_CPY;
          3'd1: return tic_pkg::CLS_HI_LH;
          3'd2: return tic_pkg::CLS_HI_HL;
          3'd3: return tic_pkg::CLS_HI_HH;
          3'd5: return tic_pkg::CLS_CMP_LH;
          3'd6: return tic_pkg::CLS_CMP_HL;
          3'd7: return tic_pkg::CLS_CMP_HH;
          default: return tic_pkg::CLS_UNDEF;
        endcase
      end
      4'h5: return w[11] ? tic_pkg::CLS_LDR_REG : tic_pkg::CLS_STR_REG;
      4'h6: return tic_pkg::CLS_LDST_IMM5;
      4'h7: return tic_pkg::CLS_LDSTB_IMM5;
      4'h8: return tic_pkg::CLS_LDSTH_IMM5;
      4'h9: return tic_pkg::CLS_LDST_SP;
      4'hA: return tic_pkg::CLS_ADD_PCSP;
      4'hB: begin
        case (w[11:8])
          4'h0: return tic_pkg::CLS_ADJ_SP;
          4'h2: return tic_pkg::CLS_EXTEND;
          4'h4, 4'h5, 4'hC, 4'hD: return tic_pkg::CLS_PUSH_POP;
          4'h6: begin
            if (w[7:4] == 4'h5 && w[2:0] == 3'd0) return tic_pkg::CLS_SETEND;
            if (w[7:5] == 3'd3 && !w[3]) return tic_pkg::CLS_CPS;
            return tic_pkg::CLS_UNDEF;
          end
          4'hA: return tic_pkg::CLS_REV;
          4'hE: return tic_pkg::CLS_BKPT;
          default: return tic_pkg::CLS_UNDEF;
        endcase
      end
      4'hC: return tic_pkg::CLS_LDM_STM;
      4'hD: begin
        if (w[11:8] < 4'hE) return tic_pkg::CLS_BCOND;
        return w[8] ? tic_pkg::CLS_SWI : tic_pkg::CLS_UDF;
      end
      4'hE: begin
        if (!w[11]) return tic_pkg::CLS_B;
        return w[0] ? tic_pkg::CLS_UNDEF : tic_pkg::CLS_BLX_SUFFIX;
      end
      default: return tic_pkg::CLS_BL_SUFFIX;
    endcase
  endfunction

  task automatic predict_decode(input logic [15:0] w);
    decode_t d;
    d.instr         = w;
    d.prefix_event  = tic_pkg::EV_NONE;
    d.prefix_offset = 11'd0;
    if (w[15:11] == tic_pkg::OP5_PREFIX) begin
      d.instr_class = tic_pkg::CLS_PREFIX;
      if (bl_prefix_held) begin
        d.prefix_event  = tic_pkg::EV_ORPHAN_NEW;
        d.prefix_offset = bl_prefix_offset;
      end else begin
        d.prefix_event = tic_pkg::EV_HELD;
      end
      bl_prefix_held   = 1'b1;
      bl_prefix_offset = w[10:0];
    end else begin
      d.instr_class = classify_halfword(w);
      if (bl_prefix_held) begin
        d.prefix_event  = (w[15:11] == tic_pkg::OP5_BLX_SUFFIX ||
                           w[15:11] == tic_pkg::OP5_BL_SUFFIX) ?
                          tic_pkg::EV_PAIRED : tic_pkg::EV_ORPHAN;
        d.prefix_offset = bl_prefix_offset;
        bl_prefix_held   = 1'b0;
        bl_prefix_offset = 11'd0;
      end
    end
    d.prefix_pending = bl_prefix_held;
    predicted_decodes.push_back(d);
  endtask

  // Driver: a stalled request holds; otherwise the next halfword goes out or the port idles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_decode(in_instr);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (halfword_q.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_instr <= halfword_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    decode_t d;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_decodes.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result with no request waiting, class %0d event %0d",
                     $realtime, out_instr_class, out_prefix_event);
        end else begin
          d = predicted_decodes.pop_front();
          if (out_instr_class !== d.instr_class || out_prefix_event !== d.prefix_event ||
              out_prefix_offset !== d.prefix_offset ||
              out_prefix_pending !== d.prefix_pending) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: instr %h exp %0d/%0d/%h/%0b got %0d/%0d/%h/%0b",
                       $realtime, d.instr, d.instr_class, d.prefix_event,
                       d.prefix_offset, d.prefix_pending, out_instr_class,
                       out_prefix_event, out_prefix_offset, out_prefix_pending);
          end
        end
      end
      out_stall <= take_break();
    end
  end

  initial begin
    logic [15:0] directed[] = '{
      16'h0000, 16'hFFFF,                     // field extremes; BL suffix with nothing held
      16'h4600, 16'h4640, 16'h4400, 16'h4500, // hi-register folding and holes
      16'h4700, 16'h4200,
      16'hB650, 16'hB660, 16'hB668, 16'hBE00, // SETEND, CPS, miscellaneous hole, BKPT
      16'hDE00, 16'hDF00, 16'hD000,
      16'hF7FF, 16'hF800,                     // prefix paired with BL
      16'hF000, 16'hE801,                     // BLX suffix with bit 0 set still pairs
      16'hF123, 16'hF456, 16'h2000,           // prefix replaced, then orphaned
      16'hE800, 16'hE000                      // BLX suffix with nothing held, plain B
    };
    int kind;
    foreach (directed[i]) halfword_q.push_back(directed[i]);
    // Prefix and suffix pairs with random offsets, mixed at random with orphans and plain halfwords.
    while (halfword_q.size() < directed.size() + RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 50)
        halfword_q.push_back({tic_pkg::OP5_PREFIX, 11'($urandom)});
      if (kind < 35)
        halfword_q.push_back({($urandom_range(1) != 0) ? tic_pkg::OP5_BL_SUFFIX :
                                                         tic_pkg::OP5_BLX_SUFFIX,
                              11'($urandom)});
      else if (kind < 45)
        halfword_q.push_back(16'($urandom));
      else if (kind < 50)
        halfword_q.push_back({tic_pkg::OP5_PREFIX, 11'($urandom)});
      else if (kind < 70)
        halfword_q.push_back({($urandom_range(1) != 0) ? 4'h4 : 4'hB, 12'($urandom)});
      else
        halfword_q.push_back(16'($urandom));
    end
    total_items = halfword_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_items < total_items) @(posedge clk);
    while (predicted_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
